// ===== hdl/pts_pkg.sv =====
// Shared types and constants for the periodic task tick scheduler.
package pts_pkg;

  localparam int unsigned NumTasksDef = 8;
  localparam int unsigned MaxReports  = 8;
  localparam int unsigned DataW       = 8;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned RepW        = $clog2(MaxReports + 1);

  typedef enum logic [1:0] {
    REQ_CREATE   = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_DISPATCH = 2'd2
  } pts_req_e;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DUE    = 2'd1,
    KIND_NONE   = 2'd2
  } pts_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } pts_state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [DataW-1:0] period;
    logic [DataW-1:0] first_delay;
  } pts_req_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic            status;
    logic [IdxW-1:0] task_index;
    logic            last;
  } pts_rsp_t;

  typedef struct packed {
    logic [DataW-1:0] per;
    logic [DataW-1:0] cd;
  } pts_slot_t;

  // Ring control from the sequencer to the cell row.
  typedef struct packed {
    logic      shift;
    pts_slot_t load_data;
    pts_slot_t tail;
  } pts_ring_ctl_t;

endpackage

// ===== hdl/pts_if.sv =====
// Request and response channel interfaces.
interface pts_req_if;
  import pts_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [DataW-1:0] period;
  logic [DataW-1:0] first_delay;

  modport source(output valid, req_type, period, first_delay, input ready);
  modport sink(input valid, req_type, period, first_delay, output ready);
endinterface

interface pts_rsp_if;
  import pts_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic            status;
  logic [IdxW-1:0] task_index;
  logic            last;

  modport source(output valid, kind, status, task_index, last, input ready);
  modport sink(input valid, kind, status, task_index, last, output ready);
endinterface

// ===== hdl/pts_cell.sv =====
// One task slot of the rotating ring: period and countdown.
module pts_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic              load_i,
  input  pts_pkg::pts_slot_t nxt_i,
  input  pts_pkg::pts_slot_t load_data_i,
  output pts_pkg::pts_slot_t slot_o
);
  import pts_pkg::*;

  pts_slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = load_data_i;
    end else if (shift_i) begin
      slot_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ===== hdl/pts_ctrl.sv =====
// Walk sequencer: head update, due detection, pending result and output register.
module pts_ctrl #(
  parameter int unsigned NumTasks = pts_pkg::NumTasksDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  pts_pkg::pts_req_t     req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output pts_pkg::pts_rsp_t     rsp_o,
  input  pts_pkg::pts_slot_t    head_i,
  output pts_pkg::pts_ring_ctl_t ring_o,
  output logic [NumTasks-1:0]   load_sel_o
);
  import pts_pkg::*;

  localparam int unsigned CntW  = $clog2(NumTasks + 1);
  localparam int unsigned StepW = (NumTasks > 1) ? $clog2(NumTasks) : 1;

  pts_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RepW-1:0]  nrep_q, nrep_d;
  logic             dec_q, dec_d;
  logic             pend_vld_q, pend_vld_d;
  pts_rsp_t         pend_q, pend_d;
  logic             out_vld_q, out_vld_d;
  pts_rsp_t         out_q, out_d;

  logic             out_free;
  logic             head_active;
  logic [DataW-1:0] cd_m1;
  logic [DataW-1:0] new_cd;
  logic             due;
  logic             create_ok;
  logic             ring_shift;

  assign out_free    = !out_vld_q || rsp_ready_i;
  assign head_active = CntW'(step_q) < cnt_q;
  assign cd_m1       = head_i.cd - DataW'(1);

  always_comb begin
    new_cd = head_i.cd;
    if (dec_q && head_active) begin
      new_cd = (cd_m1 == '0) ? head_i.per : cd_m1;
    end
  end

  assign due = head_active && (new_cd == DataW'(1)) && (nrep_q < RepW'(MaxReports));

  assign ring_o.shift      = ring_shift;
  assign ring_o.tail.per   = head_i.per;
  assign ring_o.tail.cd    = new_cd;
  assign ring_o.load_data.per = req_i.period;
  assign ring_o.load_data.cd  = req_i.first_delay;

  always_comb begin
    for (int i = 0; i < NumTasks; i++) begin
      load_sel_o[i] = create_ok && (cnt_q == CntW'(i));
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    nrep_d       = nrep_q;
    dec_d        = dec_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    out_vld_d    = out_vld_q && !rsp_ready_i;
    out_d        = out_q;
    ring_shift   = 1'b0;
    create_ok    = 1'b0;
    req_ready_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (pts_req_e'(req_i.req_type))
            REQ_CREATE: begin
              state_d    = ST_FIN;
              pend_vld_d = 1'b1;
              if (cnt_q < CntW'(NumTasks)) begin
                create_ok = 1'b1;
                cnt_d     = cnt_q + CntW'(1);
                pend_d    = '{kind: KIND_CREATE, status: 1'b0,
                              task_index: IdxW'(cnt_q), last: 1'b0};
              end else begin
                pend_d    = '{kind: KIND_CREATE, status: 1'b1,
                              task_index: '0, last: 1'b0};
              end
            end
            REQ_TICK, REQ_DISPATCH: begin
              state_d    = ST_WALK;
              step_d     = '0;
              nrep_d     = '0;
              pend_vld_d = 1'b0;
              dec_d      = (pts_req_e'(req_i.req_type) == REQ_TICK);
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      ST_WALK: begin
        // A due slot displaces the pending one; hold the ring if it cannot leave.
        if (!(due && pend_vld_q && !out_free)) begin
          ring_shift = 1'b1;
          if (due) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_d     = '{kind: KIND_DUE, status: 1'b0,
                           task_index: IdxW'(step_q), last: 1'b0};
            pend_vld_d = 1'b1;
            nrep_d     = nrep_q + RepW'(1);
          end
          if (step_q == StepW'(NumTasks - 1)) begin
            state_d = ST_FIN;
          end else begin
            step_d = step_q + StepW'(1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d = '{kind: KIND_NONE, status: 1'b0, task_index: '0, last: 1'b1};
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      cnt_q      <= '0;
      nrep_q     <= '0;
      dec_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      cnt_q      <= cnt_d;
      nrep_q     <= nrep_d;
      dec_q      <= dec_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

endmodule

// ===== hdl/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler.
//
// Keeps up to NumTasks periodic tasks in a ring of cells, each holding one
// task's 8-bit period and 8-bit countdown. A create request fills the next
// free slot and answers with one create status (ok with the slot number, or
// table full); the status waits in the pending register until the response
// register is free, and the next request is taken once it has moved there.
// A tick or dispatch request rotates the whole ring once, one slot per cycle
// unless a due report is held back by the response channel, through a single
// head update (decrement with wrap and reload on zero for a tick, no change
// for a dispatch); each created slot whose countdown is then one is reported
// as due, in slot order, at most eight per request, and the last response
// carries last = 1. If nothing is due one "no task due" response is given.
// A tick or dispatch occupies the block for its accept, NumTasks rotation
// steps and one finish step, longer while the response channel is held off.
// Requests are taken one at a time; request code 3 is accepted and dropped.
// The slot tables come up undefined; only created slots are ever looked at.
module periodic_task_tick_scheduler #(
  parameter int unsigned NumTasks = pts_pkg::NumTasksDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pts_req_if.sink         req_i,
  pts_rsp_if.source       rsp_o
);
  import pts_pkg::*;

  pts_req_t              req;
  pts_rsp_t              rsp;
  pts_ring_ctl_t         ring;
  logic [NumTasks-1:0]   load_sel;
  pts_slot_t             slots [NumTasks];
  pts_slot_t             nxt   [NumTasks];

  assign req.req_type    = req_i.req_type;
  assign req.period      = req_i.period;
  assign req.first_delay = req_i.first_delay;

  pts_ctrl #(
    .NumTasks(NumTasks)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp),
    .head_i      (slots[0]),
    .ring_o      (ring),
    .load_sel_o  (load_sel)
  );

  assign rsp_o.kind       = rsp.kind;
  assign rsp_o.status     = rsp.status;
  assign rsp_o.task_index = rsp.task_index;
  assign rsp_o.last       = rsp.last;

  // Ring: slot 0 sits at the head; each step every cell takes its upper
  // neighbor, and the top cell takes the updated head slot.
  for (genvar i = 0; i < NumTasks; i++) begin : g_cell
    if (i == NumTasks - 1) begin : g_top
      assign nxt[i] = ring.tail;
    end else begin : g_mid
      assign nxt[i] = slots[i+1];
    end

    pts_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (ring.shift),
      .load_i      (load_sel[i]),
      .nxt_i       (nxt[i]),
      .load_data_i (ring.load_data),
      .slot_o      (slots[i])
    );
  end

endmodule

// ===== hdl/pts_checker.sv =====
// Port-level checks for the periodic task tick scheduler, bound to the top.
module pts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_kind_i,
  input logic       rsp_status_i,
  input logic [2:0] rsp_task_index_i,
  input logic       rsp_last_i
);
  import pts_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_kind_i) &&
      $stable(rsp_status_i) && $stable(rsp_task_index_i) && $stable(rsp_last_i))
    else $error("response changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_kind_i == KIND_CREATE || rsp_kind_i == KIND_DUE ||
      rsp_kind_i == KIND_NONE))
    else $error("illegal response kind");

  a_none_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_kind_i == KIND_NONE |->
      rsp_last_i && !rsp_status_i && rsp_task_index_i == '0)
    else $error("malformed no-task-due response");

  a_full_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i |->
      rsp_kind_i == KIND_CREATE && rsp_task_index_i == '0)
    else $error("full status outside a create response");

  a_create_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_kind_i == KIND_CREATE |-> rsp_last_i)
    else $error("create response without last");

endmodule

bind periodic_task_tick_scheduler pts_checker u_pts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_kind_i       (rsp_o.kind),
  .rsp_status_i     (rsp_o.status),
  .rsp_task_index_i (rsp_o.task_index),
  .rsp_last_i       (rsp_o.last)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the periodic task tick scheduler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  // Request code 3 has no meaning; the block takes it and drops it.
  localparam logic [1:0] ReqUnused = 2'd3;
  // Random requests that actually do something (code 3 not counted).
  localparam int unsigned RandomItems = 240;
  // Cycles with no handshake on either channel before we give up.
  localparam int unsigned StallLimit = 3000;
  // Long response hold-off; far more than one walk, so the block backs up.
  localparam int unsigned HoldCycles = 400;
  // Margin after the last report, enough for two full walks.
  localparam int unsigned TailCycles = 2 * NumTasksDef + 4;

  // Shadow copy of the task table. Every accepted request is played into it
  // and the reports it must cause are queued in order; each response from
  // the block is then matched against the oldest queued report.
  class task_table_shadow;
    logic [DataW-1:0] period_q [NumTasksDef];
    logic [DataW-1:0] count_q  [NumTasksDef];
    int unsigned      created;
    pts_rsp_t         due_reports [$];
    int unsigned      failures;
    int unsigned      n_full, n_due, n_none, n_walks;

    function new();
      created  = 0;
      failures = 0;
      n_full   = 0;
      n_due    = 0;
      n_none   = 0;
      n_walks  = 0;
    endfunction

    function pts_rsp_t make_rsp(logic [1:0] kind, logic status, int unsigned slot,
                                logic last);
      pts_rsp_t r;
      r.kind       = kind;
      r.status     = status;
      r.task_index = IdxW'(slot);
      r.last       = last;
      return r;
    endfunction

    // Walk of created slots: every slot at one is due, capped at MaxReports.
    function void queue_due_slots();
      int unsigned hits [$];
      n_walks++;
      for (int unsigned i = 0; i < created; i++) begin
        if (count_q[i] == 8'd1 && hits.size() < MaxReports) hits.push_back(i);
      end
      if (hits.size() == 0) begin
        n_none++;
        due_reports.push_back(make_rsp(KIND_NONE, 1'b0, 0, 1'b1));
      end else begin
        foreach (hits[k]) begin
          n_due++;
          due_reports.push_back(make_rsp(KIND_DUE, 1'b0, hits[k], k == hits.size() - 1));
        end
      end
    endfunction

    function void apply_request(pts_req_t r);
      case (r.req_type)
        REQ_CREATE: begin
          if (created < NumTasksDef) begin
            period_q[created] = r.period;
            count_q[created]  = r.first_delay;
            due_reports.push_back(make_rsp(KIND_CREATE, 1'b0, created, 1'b1));
            created++;
          end else begin
            n_full++;
            due_reports.push_back(make_rsp(KIND_CREATE, 1'b1, 0, 1'b1));
          end
        end
        REQ_TICK: begin
          // 8-bit wrap on decrement; a countdown landing on zero reloads
          for (int unsigned i = 0; i < created; i++) begin
            count_q[i] = count_q[i] - 8'd1;
            if (count_q[i] == 8'd0) count_q[i] = period_q[i];
          end
          queue_due_slots();
        end
        REQ_DISPATCH: queue_due_slots();
        default: ;
      endcase
    endfunction

    function void check_report(pts_rsp_t got);
      pts_rsp_t want;
      if (due_reports.size() == 0) begin
        failures++;
        $error("unexpected response: kind %0d status %0d task_index %0d last %0d",
               got.kind, got.status, got.task_index, got.last);
        return;
      end
      want = due_reports.pop_front();
      if (got.kind !== want.kind) begin
        failures++;
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      end
      if (got.status !== want.status) begin
        failures++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
      if (got.task_index !== want.task_index) begin
        failures++;
        $error("task_index: expected %0d, actual %0d", want.task_index, got.task_index);
      end
      if (got.last !== want.last) begin
        failures++;
        $error("last: expected %0d, actual %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pts_req_if req_ch ();
  pts_rsp_if rsp_ch ();

  periodic_task_tick_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  task_table_shadow shadow = new();

  // quiet: no random idling on either side while set.
  // hold_ask/hold_seen: bumping hold_ask asks the receiver for one long hold-off.
  logic        quiet = 1'b0;
  int unsigned hold_ask = 0;
  int unsigned n_requests = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one request and wait for the handshake. All signals are read right
  // after the edge, so they still hold the values the block sampled.
  task automatic send_request(input logic [1:0] rt, input logic [DataW-1:0] per,
                              input logic [DataW-1:0] dly);
    pts_req_t r;
    r.req_type    = rt;
    r.period      = per;
    r.first_delay = dly;
    while (!quiet && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rt;
    req_ch.period      <= per;
    req_ch.first_delay <= dly;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    shadow.apply_request(r);
    n_requests++;
  endtask

  // Stop offering and wait until every queued report has come back.
  // Always waits at least one edge, so valid never gets two updates in a step.
  task automatic wait_all_reported();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (shadow.due_reports.size() != 0);
  endtask

  // Response side: check each accepted report, then pick ready for the next
  // edge. A hold-off request keeps ready low for HoldCycles counted here.
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    pts_rsp_t    got;
    hold_seen    = 0;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.kind       = rsp_ch.kind;
        got.status     = rsp_ch.status;
        got.task_index = rsp_ch.task_index;
        got.last       = rsp_ch.last;
        shadow.check_report(got);
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  // Watchdog: a run that stops moving ends as a failure.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles, %0d reports outstanding",
                 idle_cycles, shadow.due_reports.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned pick;
    logic [1:0]  rt;
    counted            = 0;
    rst_ni             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_DISPATCH;
    req_ch.period      = '0;
    req_ch.first_delay = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: walks over an empty table, the dropped code, then fill the
    // table with edge values (zero period and delay wrap to 255, 255/255,
    // period one that is due on every tick), overflow it, and tick.
    send_request(REQ_DISPATCH, 8'h00, 8'h00);
    send_request(REQ_TICK,     8'hFF, 8'hFF);
    send_request(ReqUnused,    8'hFF, 8'hFF);
    send_request(REQ_CREATE,   8'h00, 8'h00);
    send_request(REQ_CREATE,   8'hFF, 8'hFF);
    send_request(REQ_CREATE,   8'h01, 8'h01);
    send_request(REQ_CREATE,   8'h02, 8'h02);
    send_request(REQ_DISPATCH, 8'h00, 8'h00);
    send_request(REQ_TICK,     8'h00, 8'h00);
    send_request(REQ_TICK,     8'h00, 8'h00);
    send_request(ReqUnused,    8'h5A, 8'hA5);
    send_request(REQ_CREATE,   8'h03, 8'h01);
    send_request(REQ_CREATE,   8'h05, 8'h04);
    send_request(REQ_CREATE,   8'h07, 8'h00);
    send_request(REQ_CREATE,   8'h06, 8'h80);
    // table is full from here on
    send_request(REQ_CREATE,   8'hA5, 8'h5A);
    send_request(REQ_CREATE,   8'hFF, 8'h00);
    send_request(REQ_DISPATCH, 8'h00, 8'h00);
    send_request(REQ_TICK,     8'h00, 8'h00);
    send_request(REQ_TICK,     8'h00, 8'h00);
    send_request(REQ_TICK,     8'h00, 8'h00);

    // Random part: mostly ticks so the long periods come round, with
    // dispatches, overflowing creates and some dropped codes mixed in.
    while (counted < RandomItems) begin
      pick = $urandom_range(99);
      if (pick < 55)      rt = REQ_TICK;
      else if (pick < 75) rt = REQ_DISPATCH;
      else if (pick < 92) rt = REQ_CREATE;
      else                rt = ReqUnused;
      send_request(rt, 8'($urandom_range(255)), 8'($urandom_range(255)));
      if (rt != ReqUnused) begin
        counted++;
        // long response hold-off while requests keep coming
        if (counted == 60) hold_ask <= hold_ask + 1;
        // sender pause until the block has answered everything
        if (counted == 140) wait_all_reported();
      end
      quiet <= (counted >= 180 && counted < 240);
    end

    wait_all_reported();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d walks (%0d due reports, %0d empty), %0d overflows",
             n_requests, shadow.n_walks, shadow.n_due, shadow.n_none, shadow.n_full);
    $display("tasks created %0d, check failures %0d", shadow.created, shadow.failures);
    if (shadow.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
